// ===== hdl/sdff_pkg.sv =====
`default_nettype none
package sdff_pkg;

  localparam int MAX_FIELD_DEF = 40;
  localparam int NUM_DIGITS    = 20;
  localparam int DIG_CNT_W     = 5;

  // size modifier codes
  localparam logic [2:0] SIZE_NONE = 3'd0;
  localparam logic [2:0] SIZE_H    = 3'd1;
  localparam logic [2:0] SIZE_HH   = 3'd2;
  localparam logic [2:0] SIZE_L    = 3'd3;
  localparam logic [2:0] SIZE_LL   = 3'd4;

  // flag bit positions
  localparam int FLAG_LEFT  = 0;
  localparam int FLAG_ZERO  = 1;
  localparam int FLAG_PLUS  = 2;
  localparam int FLAG_SPACE = 3;
  localparam int FLAG_PREC  = 4;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_PLAN,
    ST_EMIT,
    ST_EMPTY
  } sdff_state_t;

  // emit segments, in output order
  typedef enum logic [2:0] {
    SEG_LPAD,
    SEG_SIGN,
    SEG_ZERO,
    SEG_DIGIT,
    SEG_RPAD,
    SEG_DONE
  } sdff_seg_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic plan;
    logic emit_start;
    logic emit_step;
  } sdff_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic emit_last;
    logic empty;
  } sdff_stat_t;

endpackage
`default_nettype wire

// ===== hdl/sdff_if.sv =====
`default_nettype none
interface sdff_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [2:0]  size_modifier;
  logic [4:0]  flags;
  logic [5:0]  field_width;
  logic [5:0]  digit_precision;
  modport source (output valid, value, size_modifier, flags, field_width,
                  digit_precision, input ready);
  modport sink (input valid, value, size_modifier, flags, field_width,
                digit_precision, output ready);
endinterface

interface sdff_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       is_last;
  logic       no_text;
  modport source (output valid, character, is_last, no_text, input ready);
  modport sink (input valid, character, is_last, no_text, output ready);
endinterface
`default_nettype wire

// ===== hdl/sdff_datapath.sv =====
`default_nettype none
module sdff_datapath
  import sdff_pkg::*;
#(
  parameter int MAX_FIELD = MAX_FIELD_DEF
) (
  input  wire logic        clk,
  input  wire logic [63:0] value,
  input  wire logic [2:0]  size_modifier,
  input  wire logic [4:0]  flags,
  input  wire logic [5:0]  field_width,
  input  wire logic [5:0]  digit_precision,
  input  wire sdff_cmd_t   cmd,
  output sdff_stat_t       stat,
  output logic [7:0]       character
);

  localparam int CW = $clog2(MAX_FIELD + 2);

  logic [63:0] mag_r, mag_nxt;
  logic        neg_r;
  logic [4:0]  flags_r;
  logic [5:0]  w_r, p_r;
  logic [79:0] bcd_vec_r, bcd_vec_nxt;
  logic [6:0]  bit_cnt_r;
  logic [DIG_CNT_W-1:0] nd_r;
  logic [7:0]  sign_ch_r;
  logic        has_sign_r;
  logic [CW-1:0] pad_r, zeros_r;
  logic        lpad_r, zfill_r;
  sdff_seg_t   seg_r, seg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // narrowing by size modifier
  logic [63:0] narrowed;
  always_comb begin
    case (size_modifier)
      SIZE_H:          narrowed = {{48{value[15]}}, value[15:0]};
      SIZE_HH:         narrowed = {{56{value[7]}}, value[7:0]};
      SIZE_L, SIZE_LL: narrowed = value;
      default:         narrowed = {{32{value[31]}}, value[31:0]};
    endcase
  end

  // double dabble step: add 3 to digits >= 5 then shift in next bit
  always_comb begin
    logic [79:0] adj;
    adj = bcd_vec_r;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_vec_r[d*4 +: 4] >= 4'd5) adj[d*4 +: 4] = bcd_vec_r[d*4 +: 4] + 4'd3;
    end
    bcd_vec_nxt = {adj[78:0], mag_r[63]};
    mag_nxt = {mag_r[62:0], 1'b0};
  end

  // number of significant digits
  logic [DIG_CNT_W-1:0] nd_calc;
  always_comb begin
    nd_calc = '0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd_vec_r[d*4 +: 4] != 4'd0) nd_calc = DIG_CNT_W'(d + 1);
    end
  end

  // field planning
  logic [5:0]  w_c, p_c, prec;
  logic [6:0]  nd_eff, zeros_c, body_c, pad_c;
  logic [7:0]  sign_c;
  logic        sgn_c;
  always_comb begin
    w_c  = (w_r > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : w_r;
    p_c  = (p_r > 6'(MAX_FIELD)) ? 6'(MAX_FIELD) : p_r;
    prec = flags_r[FLAG_PREC] ? p_c : 6'd1;
    nd_eff = (nd_calc == '0) ? ((prec == 6'd0) ? 7'd0 : 7'd1) : 7'(nd_calc);
    zeros_c = ({1'b0, prec} > nd_eff) ? 7'({1'b0, prec} - nd_eff) : 7'd0;
    sgn_c = neg_r | flags_r[FLAG_PLUS] | flags_r[FLAG_SPACE];
    sign_c = neg_r ? CHAR_MINUS : (flags_r[FLAG_PLUS] ? CHAR_PLUS : CHAR_SPACE);
    body_c = 7'(sgn_c) + zeros_c + nd_eff;
    pad_c = ({1'b0, w_c} > body_c) ? 7'({1'b0, w_c} - body_c) : 7'd0;
  end

  logic zmode;
  assign zmode = !flags_r[FLAG_LEFT] && flags_r[FLAG_ZERO] && !flags_r[FLAG_PREC];

  // segment sequencing
  function automatic sdff_seg_t first_seg(sdff_seg_t s, logic [CW-1:0] pad,
                                           logic sg, logic [CW-1:0] z,
                                           logic [DIG_CNT_W-1:0] n, logic lp);
    sdff_seg_t r;
    r = s;
    for (int i = 0; i < 5; i++) begin
      case (r)
        SEG_LPAD:  if (!lp || pad == '0) r = SEG_SIGN;
        SEG_SIGN:  if (!sg) r = SEG_ZERO;
        SEG_ZERO:  if (z == '0) r = SEG_DIGIT;
        SEG_DIGIT: if (n == '0) r = SEG_RPAD;
        SEG_RPAD:  if (lp || pad == '0) r = SEG_DONE;
        default:   r = SEG_DONE;
      endcase
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] seg_len(sdff_seg_t s, logic [CW-1:0] pad,
                                            logic [CW-1:0] z,
                                            logic [DIG_CNT_W-1:0] n);
    case (s)
      SEG_LPAD, SEG_RPAD: return pad;
      SEG_SIGN:           return CW'(1);
      SEG_ZERO:           return z;
      SEG_DIGIT:          return CW'(n);
      default:            return '0;
    endcase
  endfunction

  sdff_seg_t seg_after;
  always_comb begin
    seg_after = SEG_DONE;
    case (seg_r)
      SEG_LPAD:  seg_after = SEG_SIGN;
      SEG_SIGN:  seg_after = SEG_ZERO;
      SEG_ZERO:  seg_after = SEG_DIGIT;
      SEG_DIGIT: seg_after = SEG_RPAD;
      default:   seg_after = SEG_DONE;
    endcase
    seg_after = first_seg(seg_after, pad_r, has_sign_r, zeros_r, nd_r, lpad_r);
    if (cnt_r > CW'(1)) begin
      seg_nxt = seg_r;
      cnt_nxt = cnt_r - CW'(1);
    end else begin
      seg_nxt = seg_after;
      cnt_nxt = seg_len(seg_after, pad_r, zeros_r, nd_r);
    end
  end

  // digit of the current position (most significant first)
  logic [DIG_CNT_W-1:0] dig_idx;
  assign dig_idx = DIG_CNT_W'(cnt_r - CW'(1));
  always_comb begin
    case (seg_r)
      SEG_LPAD:  character = zfill_r ? CHAR_ZERO : CHAR_SPACE;
      SEG_SIGN:  character = sign_ch_r;
      SEG_ZERO:  character = CHAR_ZERO;
      SEG_DIGIT: character = CHAR_ZERO | {4'd0, bcd_vec_r[dig_idx*4 +: 4]};
      SEG_RPAD:  character = CHAR_SPACE;
      default:   character = 8'd0;
    endcase
  end

  assign stat.conv_done = (bit_cnt_r == 7'd0);
  assign stat.emit_last = (seg_nxt == SEG_DONE);
  assign stat.empty     = (seg_r == SEG_DONE);

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r     <= narrowed[63] ? (64'd0 - narrowed) : narrowed;
      neg_r     <= narrowed[63];
      flags_r   <= flags;
      w_r       <= field_width;
      p_r       <= digit_precision;
      bcd_vec_r <= '0;
      bit_cnt_r <= 7'd64;
    end else if (cmd.conv_step) begin
      mag_r     <= mag_nxt;
      bcd_vec_r <= bcd_vec_nxt;
      bit_cnt_r <= bit_cnt_r - 7'd1;
    end
    if (cmd.plan) begin
      nd_r       <= DIG_CNT_W'(nd_eff);
      // zero-pad: padding becomes zeros after the sign
      zeros_r    <= zmode ? CW'(zeros_c + pad_c) : CW'(zeros_c);
      pad_r      <= zmode ? '0 : CW'(pad_c);
      has_sign_r <= sgn_c;
      sign_ch_r  <= sign_c;
      lpad_r     <= !flags_r[FLAG_LEFT];
      zfill_r    <= zmode;
    end
    if (cmd.emit_start) begin
      // start at the first non-empty segment
      seg_r <= first_seg(SEG_LPAD, pad_r, has_sign_r, zeros_r, nd_r, lpad_r);
      cnt_r <= seg_len(first_seg(SEG_LPAD, pad_r, has_sign_r, zeros_r, nd_r, lpad_r),
                       pad_r, zeros_r, nd_r);
    end else if (cmd.emit_step) begin
      seg_r <= seg_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sdff_ctrl.sv =====
`default_nettype none
module sdff_ctrl
  import sdff_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic      out_is_last,
  output logic      out_no_text,
  input  wire sdff_stat_t stat,
  output sdff_cmd_t cmd
);

  sdff_state_t state_r, state_nxt;
  logic        start_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_CONV;
      ST_CONV:  if (stat.conv_done) state_nxt = ST_PLAN;
      ST_PLAN:  state_nxt = ST_EMIT;
      ST_EMIT:  if (!start_r && out_ready && (stat.emit_last || stat.empty))
                  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    out_is_last = 1'b0;
    out_no_text = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_CONV: cmd.conv_step = !stat.conv_done;
      ST_PLAN: cmd.plan = 1'b1;
      ST_EMIT: begin
        cmd.emit_start = start_r;
        out_valid = !start_r;
        out_is_last = stat.emit_last || stat.empty;
        out_no_text = stat.empty;
        cmd.emit_step = !start_r && out_ready;
      end
      default: ;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= (state_r == ST_PLAN);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/signed_decimal_field_formatter.sv =====
// flow: the idle state accepts a request, then come the bit-serial
//   conversion, the plan state, the emit setup step and the output of
//   one character per cycle while out_ready is high (1 to MAX_FIELD + 1
//   results); the double dabble converter and the idle state that takes
//   the request serve one request at a time
// reset: synchronous active-low rst_n returns the controller to idle
`default_nettype none
module signed_decimal_field_formatter
  import sdff_pkg::*;
#(
  parameter int MAX_FIELD = MAX_FIELD_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  sdff_in_if.sink    in_ch,
  sdff_out_if.source out_ch
);

  sdff_cmd_t  cmd;
  sdff_stat_t stat;
  logic [7:0] ch;

  sdff_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_is_last(out_ch.is_last), .out_no_text(out_ch.no_text),
    .stat, .cmd
  );

  sdff_datapath #(.MAX_FIELD(MAX_FIELD)) u_dp (
    .clk,
    .value(in_ch.value), .size_modifier(in_ch.size_modifier),
    .flags(in_ch.flags), .field_width(in_ch.field_width),
    .digit_precision(in_ch.digit_precision),
    .cmd, .stat, .character(ch)
  );

  // empty field reports character zero
  assign out_ch.character = out_ch.no_text ? 8'd0 : ch;

endmodule
`default_nettype wire

// ===== hdl/sdff_checker.sv =====
`default_nettype none
module sdff_props (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_is_last,
  input wire logic out_no_text
);

  // no new request accepted while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken during output");

  // empty field is always the last result
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_text |-> out_is_last) else $error("empty not last");

  // after the last result the block is ready again
  a_ready_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_is_last |=> in_ready)
    else $error("not ready after last");

  // acceptance leads to conversion, not immediate output
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid) else $error("output too early");

endmodule

bind signed_decimal_field_formatter sdff_props u_chk (
  .clk, .rst_n,
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_is_last(out_ch.is_last), .out_no_text(out_ch.no_text)
);
`default_nettype wire

// ===== sim/sdff_checker.sv =====
`timescale 1ns / 100ps
module sdff_checker
  import sdff_pkg::*;
#(
  parameter int MAX_FIELD = MAX_FIELD_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  sdff_in_if       in_ch,
  sdff_out_if      out_ch,
  output int       fail_cnt,
  output int       chars_pending,
  output int       req_cnt,
  output int       char_cnt
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       empty;
  } glyph_t;

  glyph_t field_q[$];

  initial begin
    fail_cnt = 0;
    req_cnt  = 0;
    char_cnt = 0;
  end

  assign chars_pending = field_q.size();

  // sign-extend the argument from the width chosen by the size code
  function automatic logic [63:0] narrowed(logic [63:0] raw, logic [2:0] size);
    case (size)
      SIZE_H:         return {{48{raw[15]}}, raw[15:0]};
      SIZE_HH:        return {{56{raw[7]}}, raw[7:0]};
      SIZE_L, SIZE_LL: return raw;
      default:        return {{32{raw[31]}}, raw[31:0]};
    endcase
  endfunction

  function automatic void push_glyph(logic [7:0] ch);
    glyph_t g;
    g.ch = ch;
    g.last = 1'b0;
    g.empty = 1'b0;
    field_q.push_back(g);
  endfunction

  // build the whole formatted field for one request
  function automatic void format_field(logic [63:0] raw, logic [2:0] size,
                                       logic [4:0] fl, logic [5:0] w_in,
                                       logic [5:0] p_in);
    logic [63:0] v, mag;
    logic [7:0]  digs[20];
    logic [7:0]  sign;
    int nd, w, p, prec, zeros, body, pad, start, i;
    glyph_t g;
    v = narrowed(raw, size);
    mag = v[63] ? (64'd0 - v) : v;
    w = (w_in > MAX_FIELD) ? MAX_FIELD : w_in;
    p = (p_in > MAX_FIELD) ? MAX_FIELD : p_in;
    prec = fl[FLAG_PREC] ? p : 1;
    nd = 0;
    start = field_q.size();
    if (!(mag == 0 && prec == 0)) begin
      do begin
        digs[nd] = CHAR_ZERO + 8'(mag % 10);
        mag = mag / 10;
        nd++;
      end while (mag != 0 && nd < 20);
    end
    zeros = (prec > nd) ? prec - nd : 0;
    if (v[63]) sign = CHAR_MINUS;
    else if (fl[FLAG_PLUS]) sign = CHAR_PLUS;
    else if (fl[FLAG_SPACE]) sign = CHAR_SPACE;
    else sign = 8'd0;
    body = (sign != 0) + zeros + nd;
    pad = (w > body) ? w - body : 0;
    if (fl[FLAG_LEFT]) begin
      if (sign != 0) push_glyph(sign);
      for (i = 0; i < zeros; i++) push_glyph(CHAR_ZERO);
      for (i = nd; i > 0; i--) push_glyph(digs[i-1]);
      for (i = 0; i < pad; i++) push_glyph(CHAR_SPACE);
    end else if (fl[FLAG_ZERO] && !fl[FLAG_PREC]) begin
      if (sign != 0) push_glyph(sign);
      for (i = 0; i < pad + zeros; i++) push_glyph(CHAR_ZERO);
      for (i = nd; i > 0; i--) push_glyph(digs[i-1]);
    end else begin
      for (i = 0; i < pad; i++) push_glyph(CHAR_SPACE);
      if (sign != 0) push_glyph(sign);
      for (i = 0; i < zeros; i++) push_glyph(CHAR_ZERO);
      for (i = nd; i > 0; i--) push_glyph(digs[i-1]);
    end
    if (field_q.size() == start) begin
      g.ch = 8'd0;
      g.last = 1'b1;
      g.empty = 1'b1;
      field_q.push_back(g);
    end else begin
      field_q[field_q.size()-1].last = 1'b1;
    end
  endfunction

  // predict on each accepted request, compare each accepted character
  always @(posedge clk) begin
    glyph_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        req_cnt <= req_cnt + 1;
        format_field(in_ch.value, in_ch.size_modifier, in_ch.flags,
                     in_ch.field_width, in_ch.digit_precision);
      end
      if (out_ch.valid && out_ch.ready) begin
        char_cnt <= char_cnt + 1;
        if (field_q.size() == 0) begin
          $error("character: expected none, got %h", out_ch.character);
          fail_cnt = fail_cnt + 1;
        end else begin
          want = field_q.pop_front();
          if (!want.empty && out_ch.character !== want.ch) begin
            $error("character: expected %h, got %h", want.ch, out_ch.character);
            fail_cnt = fail_cnt + 1;
          end
          if (out_ch.is_last !== want.last) begin
            $error("is_last: expected %b, got %b", want.last, out_ch.is_last);
            fail_cnt = fail_cnt + 1;
          end
          if (out_ch.no_text !== want.empty) begin
            $error("no_text: expected %b, got %b", want.empty, out_ch.no_text);
            fail_cnt = fail_cnt + 1;
          end
        end
      end
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
module tb
  import sdff_pkg::*;
;

  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD   = 400;
  localparam int RANDOM_REQS = 500;

  logic clk;
  logic rst_n;
  int   fail_cnt, chars_pending, req_cnt, char_cnt;
  int   idle_cycles;
  logic hold_req, hold_done;

  sdff_in_if  in_ch();
  sdff_out_if out_ch();

  signed_decimal_field_formatter u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sdff_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_cnt      (fail_cnt),
    .chars_pending (chars_pending),
    .req_cnt       (req_cnt),
    .char_cnt      (char_cnt)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // no-progress watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // receiver: random back-pressure plus one long hold-off
  initial begin
    int r, n;
    out_ch.ready <= 1'b0;
    hold_done = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) n = 0;
        else if (r < 90) n = $urandom_range(1, 3);
        else n = $urandom_range(10, 40);
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // drive one request and wait until it is taken
  task automatic send_req(logic [63:0] v, logic [2:0] size, logic [4:0] fl,
                          logic [5:0] w, logic [5:0] p);
    int gap;
    in_ch.valid           <= 1'b1;
    in_ch.value           <= v;
    in_ch.size_modifier   <= size;
    in_ch.flags           <= fl;
    in_ch.field_width     <= w;
    in_ch.digit_precision <= p;
    forever begin
      @(negedge clk);
      if (in_ch.ready) break;
    end
    @(posedge clk);
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 90);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand_value(logic [2:0] size);
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = 64'($signed($urandom_range(0, 400)) - 200);
      1: v = {$urandom, $urandom};
      2: v = 64'h8000_0000_0000_0000 >> $urandom_range(0, 63);
      3: v = ~(64'h8000_0000_0000_0000 >> $urandom_range(0, 63));
      4: v = 64'($signed($urandom)) * 64'($urandom_range(0, 1000));
      default: begin
        case (size)
          SIZE_HH: v = {$urandom, 24'h0, 8'($urandom)};
          SIZE_H:  v = {$urandom, 16'h0, 16'($urandom)};
          default: v = {$urandom, $urandom};
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic logic [5:0] rand_len();
    if ($urandom_range(0, 9) < 8) return 6'($urandom_range(0, 20));
    return 6'($urandom_range(0, 63));
  endfunction

  initial begin
    logic [2:0] size;
    hold_req = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid           <= 1'b0;
    in_ch.value           <= '0;
    in_ch.size_modifier   <= SIZE_NONE;
    in_ch.flags           <= '0;
    in_ch.field_width     <= '0;
    in_ch.digit_precision <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    send_req(64'd0, SIZE_NONE, 5'b10000, 6'd0, 6'd0);            // zero, precision zero
    send_req(64'd0, SIZE_NONE, 5'b10100, 6'd0, 6'd0);            // sign only
    send_req(64'd0, SIZE_NONE, 5'b10001, 6'd5, 6'd0);            // spaces only
    send_req(64'd0, SIZE_NONE, 5'b00000, 6'd0, 6'd0);
    send_req(64'h8000_0000_0000_0000, SIZE_LL, 5'b00000, 6'd0, 6'd0);
    send_req(64'h7FFF_FFFF_FFFF_FFFF, SIZE_L, 5'b00100, 6'd63, 6'd0);
    send_req(64'h0000_0000_8000_0000, SIZE_NONE, 5'b00010, 6'd20, 6'd0);
    send_req(64'hFFFF_FFFF_FFFF_FF80, SIZE_HH, 5'b01000, 6'd6, 6'd0);
    send_req(64'h1234_5678_0000_7FFF, SIZE_H, 5'b01100, 6'd0, 6'd0);  // plus beats space
    send_req(64'd123, 3'd5, 5'b00011, 6'd10, 6'd0);                  // left beats zero
    send_req(64'hFFFF_FFFF_FFFF_FFFF, 3'd6, 5'b11111, 6'd40, 6'd40);
    send_req(64'd42, 3'd7, 5'b10010, 6'd12, 6'd63);
    send_req(64'hFFFF_FFFF_FFFF_FFD6, SIZE_NONE, 5'b00010, 6'd8, 6'd0);
    send_req(64'd7, SIZE_LL, 5'b01001, 6'd63, 6'd63);
    send_req(64'h00FF, SIZE_HH, 5'b10000, 6'd3, 6'd5);
    send_req(64'h8000, SIZE_H, 5'b00110, 6'd9, 6'd0);
    send_req(64'h8000_0000_0000_0000, SIZE_LL, 5'b10001, 6'd41, 6'd41);

    // random requests, long receiver hold-off early on
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i == 40) hold_req = 1'b1;
      size = 3'($urandom_range(0, 9) < 9 ? $urandom_range(0, 4) : $urandom_range(5, 7));
      send_req(rand_value(size), size, 5'($urandom_range(0, 31)), rand_len(), rand_len());
    end
    in_ch.valid <= 1'b0;

    while (chars_pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);

    $display("covered %0d requests (all size codes, flag mixes, clamped widths)", req_cnt);
    $display("checked %0d characters, %0d mismatches", char_cnt, fail_cnt);
    if (fail_cnt == 0 && chars_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== signed_decimal_field_formatter.f =====
hdl/sdff_pkg.sv
hdl/sdff_if.sv
hdl/sdff_datapath.sv
hdl/sdff_ctrl.sv
hdl/signed_decimal_field_formatter.sv
hdl/sdff_checker.sv
sim/sdff_checker.sv
sim/tb.sv
